// File: hw/rtl/tatan_pkg.sv
// shared types, constants and the arctangent table builder for the atan2 block
package tatan_pkg;

  // sample and result widths
  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 16;
  localparam int RATIO_W  = 16;
  localparam int ANGLE_W  = 16;
  localparam int ROM_W    = 16;
  localparam int BASE_W   = 14;

  // divider: quotient bits resolved per stage and number of stages
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = RATIO_W / DIV_BITS;

  // default table resolution
  localparam int TABLE_STEPS_DEF = 255;

  // angle constants in Q3.13 radians
  localparam logic signed [ANGLE_W-1:0] PI_Q13      = 16'sd25736;
  localparam logic signed [ANGLE_W-1:0] HALF_PI_Q13 = 16'sd12868;

  // table builder constants
  localparam int          CORDIC_ITERS   = 48;
  localparam logic [63:0] QUARTER_PI_Q62 = 64'h3243F6A8885A308D;

  // sideband that travels with each word through the pipeline
  typedef struct packed {
    logic                        special;
    logic signed [ANGLE_W-1:0]   spec_angle;
    logic                        x_big;
    logic                        x_neg;
    logic                        y_neg;
    logic                        sat;
  } tatan_side_t;

  // unsigned shift-subtract division, used by the table builder
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[63:0], num[k]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // table entry: round(atan(i/steps) * 2^16) by integer cordic
  function automatic logic [ROM_W-1:0] atan_entry(input int i, input int steps);
    logic [63:0] ang [CORDIC_ITERS];
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] z;
    logic [63:0] rz;
    longint      cx;
    longint      cy;
    longint      sx;
    longint      sy;
    int          e;
    ang[0] = QUARTER_PI_Q62;
    for (int j = 1; j < CORDIC_ITERS; j++) begin
      sum = '0;
      for (int n = 0; n < 32; n++) begin
        e = j * (2 * n + 1);
        if (e <= 62) begin
          term = udiv64(64'd1 << (62 - e), 64'(2 * n + 1));
          if ((n % 2) == 0) sum = sum + term;
          else              sum = sum - term;
        end
      end
      ang[j] = sum;
    end
    cx = longint'(steps) <<< 40;
    cy = longint'(i) <<< 40;
    z  = '0;
    for (int j = 0; j < CORDIC_ITERS; j++) begin
      sx = cx >>> j;
      sy = cy >>> j;
      if (cy >= 0) begin
        cx = cx + sy;
        cy = cy - sx;
        z  = z + ang[j];
      end else begin
        cx = cx - sy;
        cy = cy + sx;
        z  = z - ang[j];
      end
    end
    rz = (z + (64'd1 << 45)) >> 46;
    if (z[63]) return '0;
    return rz[ROM_W-1:0];
  endfunction

endpackage

// File: hw/rtl/tatan_div.sv
// pipelined restoring divider: ratio = floor(lo * 2^16 / hi), DIV_BITS per stage
module tatan_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [tatan_pkg::MAG_W-1:0]   lo_i,
  input  logic [tatan_pkg::MAG_W-1:0]   hi_i,
  input  tatan_pkg::tatan_side_t        side_i,
  output logic                          out_valid_o,
  output logic [tatan_pkg::RATIO_W-1:0] ratio_o,
  output tatan_pkg::tatan_side_t        side_o
);
  import tatan_pkg::*;

  logic               vld_q  [DIV_STAGES];
  logic [MAG_W-1:0]   rem_q  [DIV_STAGES];
  logic [MAG_W-1:0]   den_q  [DIV_STAGES];
  logic [RATIO_W-1:0] quo_q  [DIV_STAGES];
  tatan_side_t        side_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic               vld_in;
    logic [MAG_W-1:0]   rem_in;
    logic [MAG_W-1:0]   den_in;
    logic [RATIO_W-1:0] quo_in;
    tatan_side_t        side_in;
    logic [MAG_W-1:0]   rem_d;
    logic [RATIO_W-1:0] quo_d;

    if (s == 0) begin : g_first
      assign vld_in  = in_valid_i;
      assign rem_in  = lo_i;
      assign den_in  = hi_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign side_in = side_q[s-1];
    end

    // resolve DIV_BITS quotient bits
    always_comb begin
      logic [MAG_W:0] r2;
      rem_d = rem_in;
      quo_d = quo_in;
      for (int k = 0; k < DIV_BITS; k++) begin
        r2 = {rem_d, 1'b0};
        if (r2 >= {1'b0, den_in}) begin
          r2    = r2 - {1'b0, den_in};
          quo_d = {quo_d[RATIO_W-2:0], 1'b1};
        end else begin
          quo_d = {quo_d[RATIO_W-2:0], 1'b0};
        end
        rem_d = r2[MAG_W-1:0];
      end
    end

    // valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    // payload
    always_ff @(posedge clk_i) begin
      rem_q[s]  <= rem_d;
      den_q[s]  <= den_in;
      quo_q[s]  <= quo_d;
      side_q[s] <= side_in;
    end
  end

  // equal magnitudes saturate the ratio
  assign out_valid_o = vld_q[DIV_STAGES-1];
  assign side_o      = side_q[DIV_STAGES-1];
  assign ratio_o     = side_q[DIV_STAGES-1].sat ? '1 : quo_q[DIV_STAGES-1];

  // remainder stays below the divisor for a regular word
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !side_o.special && !side_o.sat) |->
      (rem_q[DIV_STAGES-1] < den_q[DIV_STAGES-1]))
    else $error("divider remainder not below divisor");

endmodule

// File: hw/rtl/tatan_interp.sv
// table lookup with linear interpolation, three register stages
module tatan_interp #(
  parameter int TABLE_STEPS = tatan_pkg::TABLE_STEPS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [tatan_pkg::RATIO_W-1:0] ratio_i,
  input  tatan_pkg::tatan_side_t        side_i,
  output logic                          out_valid_o,
  output logic [tatan_pkg::BASE_W-1:0]  base_o,
  output tatan_pkg::tatan_side_t        side_o
);
  import tatan_pkg::*;

  localparam int SW = $clog2(TABLE_STEPS + 1);
  localparam int AW = RATIO_W + SW;

  // arctangent table, TABLE_STEPS+1 entries
  logic [ROM_W-1:0] rom_w [TABLE_STEPS+1];
  for (genvar i = 0; i <= TABLE_STEPS; i++) begin : g_rom
    localparam logic [ROM_W-1:0] ENTRY = atan_entry(i, TABLE_STEPS);
    assign rom_w[i] = ENTRY;
  end

  // stage 1: scale ratio to table position
  logic [AW-1:0] pos_w;
  logic [AW-1:0] ofs_w;
  logic [SW-1:0] idx_raw_w;
  logic [SW-1:0] idx_d;
  logic          small_w;

  assign pos_w     = AW'(ratio_i) * AW'(TABLE_STEPS);
  assign small_w   = (pos_w < AW'(65536));
  assign ofs_w     = pos_w - AW'(32768);
  assign idx_raw_w = ofs_w[AW-1:RATIO_W];
  assign idx_d     = (idx_raw_w > SW'(TABLE_STEPS - 1)) ? SW'(TABLE_STEPS - 1) : idx_raw_w;

  logic               v1_q;
  logic [SW-1:0]      idx_q;
  logic [15:0]        frac1_q;
  logic               small1_q;
  logic [RATIO_W-1:0] ratio1_q;
  tatan_side_t        side1_q;

  // stage 2: read neighbor entries
  logic [ROM_W-1:0] r0_w;
  logic [ROM_W-1:0] r1_w;
  logic [ROM_W-1:0] diff_d;

  assign r0_w   = rom_w[idx_q];
  assign r1_w   = rom_w[idx_q + SW'(1)];
  assign diff_d = (r1_w >= r0_w) ? (r1_w - r0_w) : '0;

  logic               v2_q;
  logic [ROM_W-1:0]   r0_q;
  logic [ROM_W-1:0]   diff_q;
  logic [15:0]        frac2_q;
  logic               small2_q;
  logic [RATIO_W-1:0] ratio2_q;
  tatan_side_t        side2_q;

  // stage 3: interpolate and round to Q3.13
  logic [31:0] prod_w;
  logic [16:0] base16_w;
  logic [16:0] rnd_w;

  assign prod_w   = 32'(diff_q) * 32'(frac2_q) + 32'd32768;
  assign base16_w = small2_q ? {1'b0, ratio2_q} : ({1'b0, r0_q} + {1'b0, prod_w[31:16]});
  assign rnd_w    = base16_w + 17'd4;

  logic              v3_q;
  logic [BASE_W-1:0] base_q;
  tatan_side_t       side3_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    frac1_q  <= ofs_w[15:0];
    small1_q <= small_w;
    ratio1_q <= ratio_i;
    side1_q  <= side_i;
    r0_q     <= r0_w;
    diff_q   <= diff_d;
    frac2_q  <= frac1_q;
    small2_q <= small1_q;
    ratio2_q <= ratio1_q;
    side2_q  <= side1_q;
    base_q   <= rnd_w[16:3];
    side3_q  <= side2_q;
  end

  assign out_valid_o = v3_q;
  assign base_o      = base_q;
  assign side_o      = side3_q;

  // table position never runs past the last segment
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !small_w) |-> (idx_raw_w <= SW'(TABLE_STEPS - 1)))
    else $error("table index beyond last segment");

  // base angle never exceeds pi/4 in Q3.13
  a_base_le_quarter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (base_q <= BASE_W'(6434)))
    else $error("base angle above pi/4");

endmodule

// File: hw/rtl/table_atan2_angle.sv
// top level: four-quadrant atan2 of a signed sample pair, pipelined
//
//  port group           dir    width  meaning
//  start_i / busy_o     in/out 1/1    input word handshake, taken when start_i && !busy_o
//  x_value_i, y_value_i in     16     signed sample components
//  valid_o / angle_rad_o out   1/16   result strobe and Q3.13 angle, one cycle each
//
// one word enters every cycle; busy_o stays low
// pipeline stages: input stage, 4 divider stages, 3 table stages, octant stage
// the divider pipeline (4 quotient bits per stage) sets the depth
// reset clears only the valid bits; words in flight are dropped
// the receiver cannot stall, so results are never held back
module table_atan2_angle #(
  parameter int TABLE_STEPS = tatan_pkg::TABLE_STEPS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [tatan_pkg::SAMPLE_W-1:0] x_value_i,
  input  logic signed [tatan_pkg::SAMPLE_W-1:0] y_value_i,
  output logic                                 valid_o,
  output logic signed [tatan_pkg::ANGLE_W-1:0]  angle_rad_o
);
  import tatan_pkg::*;

  // front end: magnitudes, ordering, special cases
  logic [SAMPLE_W:0] xneg_w;
  logic [SAMPLE_W:0] yneg_w;
  logic [MAG_W-1:0]  ax_w;
  logic [MAG_W-1:0]  ay_w;
  tatan_side_t       side_d;

  assign xneg_w = -{x_value_i[SAMPLE_W-1], x_value_i};
  assign yneg_w = -{y_value_i[SAMPLE_W-1], y_value_i};
  assign ax_w   = x_value_i[SAMPLE_W-1] ? xneg_w[MAG_W-1:0] : x_value_i[MAG_W-1:0];
  assign ay_w   = y_value_i[SAMPLE_W-1] ? yneg_w[MAG_W-1:0] : y_value_i[MAG_W-1:0];

  always_comb begin
    side_d.special    = (x_value_i == '0) || (y_value_i == '0);
    side_d.x_big      = ax_w > ay_w;
    side_d.x_neg      = x_value_i[SAMPLE_W-1];
    side_d.y_neg      = y_value_i[SAMPLE_W-1];
    side_d.sat        = ax_w == ay_w;
    if (x_value_i == '0 && y_value_i == '0) begin
      side_d.spec_angle = '0;
    end else if (x_value_i == '0) begin
      side_d.spec_angle = y_value_i[SAMPLE_W-1] ? -HALF_PI_Q13 : HALF_PI_Q13;
    end else begin
      side_d.spec_angle = x_value_i[SAMPLE_W-1] ? PI_Q13 : '0;
    end
  end

  logic             in_vld_q;
  logic [MAG_W-1:0] lo_q;
  logic [MAG_W-1:0] hi_q;
  tatan_side_t      in_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q      <= side_d.x_big ? ay_w : ax_w;
    hi_q      <= side_d.x_big ? ax_w : ay_w;
    in_side_q <= side_d;
  end

  assign busy_o = 1'b0;

  // ratio divider
  logic               div_vld_w;
  logic [RATIO_W-1:0] ratio_w;
  tatan_side_t        div_side_w;

  tatan_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_vld_q),
    .lo_i        (lo_q),
    .hi_i        (hi_q),
    .side_i      (in_side_q),
    .out_valid_o (div_vld_w),
    .ratio_o     (ratio_w),
    .side_o      (div_side_w)
  );

  // table lookup
  logic              lut_vld_w;
  logic [BASE_W-1:0] base_w;
  tatan_side_t       lut_side_w;

  tatan_interp #(
    .TABLE_STEPS (TABLE_STEPS)
  ) u_interp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_vld_w),
    .ratio_i     (ratio_w),
    .side_i      (div_side_w),
    .out_valid_o (lut_vld_w),
    .base_o      (base_w),
    .side_o      (lut_side_w)
  );

  // octant mapping
  logic signed [ANGLE_W-1:0] b_w;
  logic signed [ANGLE_W-1:0] angle_d;

  assign b_w = signed'({{(ANGLE_W-BASE_W){1'b0}}, base_w});

  always_comb begin
    if (lut_side_w.special) begin
      angle_d = lut_side_w.spec_angle;
    end else if (lut_side_w.x_big) begin
      if (!lut_side_w.x_neg) angle_d = lut_side_w.y_neg ? -b_w : b_w;
      else                   angle_d = lut_side_w.y_neg ? (b_w - PI_Q13) : (PI_Q13 - b_w);
    end else begin
      if (!lut_side_w.y_neg) begin
        angle_d = lut_side_w.x_neg ? (HALF_PI_Q13 + b_w) : (HALF_PI_Q13 - b_w);
      end else begin
        angle_d = lut_side_w.x_neg ? (-HALF_PI_Q13 - b_w) : (b_w - HALF_PI_Q13);
      end
    end
  end

  logic                      out_vld_q;
  logic signed [ANGLE_W-1:0] angle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= lut_vld_w;
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q <= angle_d;
  end

  assign valid_o     = out_vld_q;
  assign angle_rad_o = angle_q;

  // result stays within [-pi, +pi]
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (angle_rad_o <= PI_Q13 && angle_rad_o >= -PI_Q13))
    else $error("angle out of range");

  // a word leaving the table stage shows up on the result strobe next cycle
  a_strobe_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lut_vld_w |=> valid_o)
    else $error("result strobe lost");

endmodule

// File: verif/table_atan2_angle_tb.sv
// self-checking testbench for the table_atan2_angle four-quadrant arctangent block
`timescale 1ns / 100ps

module table_atan2_angle_tb;
  import tatan_pkg::*;

  localparam int STEPS      = TABLE_STEPS_DEF;
  localparam int RAND_WORDS = 1200;
  localparam int CYCLE_CAP  = 200000;

  // directed word with an optional hand-computed angle
  typedef struct {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    bit                         typed;
    logic signed [ANGLE_W-1:0]  angle;
  } aim_row_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start_i;
  logic                        busy_o;
  logic signed [SAMPLE_W-1:0]  x_value_i;
  logic signed [SAMPLE_W-1:0]  y_value_i;
  logic                        valid_o;
  logic signed [ANGLE_W-1:0]   angle_rad_o;

  logic [ROM_W-1:0]            arc_rom [STEPS+1];
  logic signed [ANGLE_W-1:0]   angle_q [$];
  bit                          typed_now;
  logic signed [ANGLE_W-1:0]   typed_angle;
  int                          errors;
  int                          cycles;
  aim_row_t                    aims [20];

  table_atan2_angle i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .x_value_i   (x_value_i),
    .y_value_i   (y_value_i),
    .valid_o     (valid_o),
    .angle_rad_o (angle_rad_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("** table_atan2_angle: FAILED **");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // angle predictor: ratio lookup with interpolation, then octant fold
  function automatic logic signed [ANGLE_W-1:0] atan2_q13(
      input logic signed [SAMPLE_W-1:0] x, input logic signed [SAMPLE_W-1:0] y);
    longint ax, ay, lo, hi, ratio, base, a, idx, f, r0, r1, b, ang;
    ax = (x < 0) ? -longint'(x) : longint'(x);
    ay = (y < 0) ? -longint'(y) : longint'(y);
    if (x == 0 && y == 0) return '0;
    if (x == 0) return (y > 0) ? HALF_PI_Q13 : -HALF_PI_Q13;
    if (y == 0) return (x > 0) ? 16'sd0 : PI_Q13;
    lo = (ay < ax) ? ay : ax;
    hi = (ay < ax) ? ax : ay;
    ratio = (lo << 16) / hi;
    if (ratio > 65535) ratio = 65535;
    if (ratio * STEPS < 65536) begin
      base = ratio;
    end else begin
      a   = ratio * STEPS - 32768;
      idx = a >> 16;
      f   = a & 16'hFFFF;
      if (idx > STEPS - 1) idx = STEPS - 1;
      r0 = arc_rom[idx];
      r1 = arc_rom[idx + 1];
      base = r0 + ((((r1 >= r0) ? r1 - r0 : 0) * f + 32768) >> 16);
    end
    b = (base + 4) >> 3;
    if (ax > ay) begin
      if (x > 0) ang = (y >= 0) ? b : -b;
      else       ang = (y >= 0) ? (PI_Q13 - b) : (b - PI_Q13);
    end else begin
      if (y >= 0) ang = (x >= 0) ? (HALF_PI_Q13 - b) : (HALF_PI_Q13 + b);
      else        ang = (x >= 0) ? (b - HALF_PI_Q13) : (-HALF_PI_Q13 - b);
    end
    return ang[ANGLE_W-1:0];
  endfunction

  // record an expectation for every word the block takes
  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o)
      angle_q.push_back(typed_now ? typed_angle : atan2_q13(x_value_i, y_value_i));
  end

  // compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (angle_q.size() == 0) begin
        report($sformatf("unexpected angle %0d", angle_rad_o));
      end else begin
        logic signed [ANGLE_W-1:0] want;
        want = angle_q.pop_front();
        if (angle_rad_o !== want)
          report($sformatf("angle_rad got %0d want %0d", angle_rad_o, want));
      end
    end
  end

  // offer one word, holding start until the block takes it
  task automatic send_word(input logic signed [SAMPLE_W-1:0] x,
                           input logic signed [SAMPLE_W-1:0] y,
                           input bit typed, input logic signed [ANGLE_W-1:0] angle,
                           input bit may_idle);
    while (may_idle && $urandom_range(99) < 37) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
    @(negedge clk_i);
    start_i     <= 1'b1;
    x_value_i   <= x;
    y_value_i   <= y;
    typed_now   = typed;
    typed_angle = angle;
    do @(posedge clk_i); while (busy_o);
  endtask

  // random sample pair shaped toward the interesting regions
  task automatic pick_pair(output logic signed [SAMPLE_W-1:0] x,
                           output logic signed [SAMPLE_W-1:0] y);
    int sel;
    sel = $urandom_range(9);
    x = SAMPLE_W'($urandom);
    y = SAMPLE_W'($urandom);
    case (sel)
      0, 1: begin
        x = $signed(16'($urandom_range(64))) - 16'sd32;
        y = $signed(16'($urandom_range(64))) - 16'sd32;
      end
      2: begin
        y = ($urandom_range(1)) ? x : -x;
        if ($urandom_range(1)) y = y + $signed(16'($urandom_range(4))) - 16'sd2;
      end
      3: begin
        if ($urandom_range(1)) x = '0;
        else y = '0;
      end
      4: begin
        x = ($urandom_range(1)) ? 16'sh8000 : 16'sh7FFF;
        if ($urandom_range(1)) y = $signed(16'($urandom_range(300))) - 16'sd150;
      end
      5: begin
        // small ratio: one component within +/-100, the other random
        y = $signed(16'($urandom_range(200))) - 16'sd100;
        if ($urandom_range(1)) begin
          x = y;
          y = SAMPLE_W'($urandom);
        end
      end
      default: ;
    endcase
  endtask

  initial begin
    logic signed [SAMPLE_W-1:0] rx, ry;
    int                         wait_cnt;
    rst_ni    = 1'b0;
    start_i   = 1'b0;
    x_value_i = '0;
    y_value_i = '0;
    typed_now = 1'b0;
    typed_angle = '0;
    errors    = 0;
    cycles    = 0;
    for (int i = 0; i <= STEPS; i++)
      arc_rom[i] = atan_entry(i, STEPS);

    // directed words: axes, origin, extremes, diagonals, small ratios
    aims = '{
      '{16'sd0,      16'sd0,      1'b1, 16'sd0},
      '{16'sd0,      16'sd5,      1'b1, HALF_PI_Q13},
      '{16'sd0,      -16'sd5,     1'b1, -HALF_PI_Q13},
      '{16'sd7,      16'sd0,      1'b1, 16'sd0},
      '{-16'sd7,     16'sd0,      1'b1, PI_Q13},
      '{16'sh8000,   16'sd0,      1'b1, PI_Q13},
      '{16'sd0,      16'sh8000,   1'b1, -HALF_PI_Q13},
      '{16'sd0,      16'sh7FFF,   1'b1, HALF_PI_Q13},
      '{16'sh7FFF,   16'sd0,      1'b1, 16'sd0},
      '{16'sh7FFF,   16'sh7FFF,   1'b0, 16'sd0},
      '{16'sh8000,   16'sh8000,   1'b0, 16'sd0},
      '{16'sh8000,   16'sh7FFF,   1'b0, 16'sd0},
      '{16'sh7FFF,   16'sh8000,   1'b0, 16'sd0},
      '{16'sd1,      16'sh7FFF,   1'b0, 16'sd0},
      '{16'sh7FFF,   16'sd1,      1'b0, 16'sd0},
      '{-16'sd1,     -16'sd1,     1'b0, 16'sd0},
      '{16'sd1000,   16'sd3,      1'b0, 16'sd0},
      '{-16'sd255,   16'sd1,      1'b0, 16'sd0},
      '{16'sd254,    -16'sd255,   1'b0, 16'sd0},
      '{-16'sd3,     16'sd4,      1'b0, 16'sd0}
    };

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (aims[i])
      send_word(aims[i].x, aims[i].y, aims[i].typed, aims[i].angle, 1'b1);

    // random words, with a stretch of back-to-back traffic
    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n == 300) begin
        @(negedge clk_i);
        start_i <= 1'b0;
        while (angle_q.size() != 0) @(posedge clk_i);
      end
      pick_pair(rx, ry);
      send_word(rx, ry, 1'b0, '0, !(n >= 500 && n < 700));
    end
    @(negedge clk_i);
    start_i <= 1'b0;

    // drain the pipeline
    wait_cnt = 0;
    while (angle_q.size() != 0 && wait_cnt < 1000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    if (angle_q.size() != 0)
      report($sformatf("%0d angle words never arrived", angle_q.size()));
    repeat (20) @(posedge clk_i);

    if (errors == 0) begin
      $display("** table_atan2_angle: PASSED **");
    end else begin
      $display("** table_atan2_angle: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/tatan_pkg.sv
hw/rtl/tatan_div.sv
hw/rtl/tatan_interp.sv
hw/rtl/table_atan2_angle.sv
verif/table_atan2_angle_tb.sv
